// ----- rtl/twc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_pkg: shared types and constants of the two-way cache tag controller
// Address split, tag store write port and configuration codes.
// ----------------------------------------------------------------------------
package twc_pkg;

  localparam int LINE_BYTES  = 16;
  localparam int SET_COUNT   = 64;
  localparam int ADDR_BITS   = 32;
  localparam int OFFSET_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS    = $clog2(SET_COUNT);
  localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS - SET_BITS;
  localparam int CNT_BITS    = 32;
  localparam int LFSR_BITS   = 16;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 1;

  typedef logic [ADDR_BITS-1:0]    addr_t;
  typedef logic [SET_BITS-1:0]     set_t;
  typedef logic [TAG_BITS-1:0]     tag_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [LFSR_BITS-1:0]    lfsr_t;
  typedef logic [CFG_BITS-1:0]     cfg_data_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [1:0]              policy_t;

  // Register indexes
  localparam cfg_idx_t CFG_POLICY = 1'd0;
  localparam cfg_idx_t CFG_SEED   = 1'd1;

  // Replacement policy codes; the unused code behaves as LRU
  localparam policy_t POLICY_LRU    = 2'd0;
  localparam policy_t POLICY_FIFO   = 2'd1;
  localparam policy_t POLICY_RANDOM = 2'd2;

  localparam lfsr_t LFSR_RESET    = 16'd44257;
  localparam lfsr_t LFSR_FEEDBACK = 16'hB400;

  // Write port of one way's tag store
  typedef struct packed {
    logic we;
    set_t set;
    tag_t tag;
  } tag_wr_t;

endpackage

// ----- rtl/two_way_cache_tag_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_way_cache_tag_controller: tag and replacement control, 2-way cache
// Looks up one byte address per word, reports hit, fill way and eviction,
// and keeps saturating access, hit, miss and eviction totals.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   in_      in         in_valid/in_stall   in_byte_address
//   out_     out        out_valid/out_stall hit, replaced, way_used,
//                                           set_index, four totals
//   cfg_     in         cfg_we              cfg_index, cfg_data
//
// One word per cycle sustained while out_ does not stall. The tag store is
// read at the accepting edge, into stage one; compare and update then go into
// the result register when stage one advances. The registered tag store read
// port is why stage one sits between acceptance and the result register.
// Reset (synchronous, rst_n low) clears valid bits, recency bits, totals and
// policy, and loads the LFSR with its default seed; tags need no clearing.
// A stall on out_ holds the result register and backs up into in_stall.
// ----------------------------------------------------------------------------
module two_way_cache_tag_controller (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  twc_pkg::addr_t      in_byte_address,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit,
  output logic                out_replaced,
  output logic                out_way_used,
  output twc_pkg::set_t       out_set_index,
  output twc_pkg::cnt_t       out_access_total,
  output twc_pkg::cnt_t       out_hit_total,
  output twc_pkg::cnt_t       out_miss_total,
  output twc_pkg::cnt_t       out_replace_total,
  // configuration
  input  logic                cfg_we,
  input  twc_pkg::cfg_idx_t   cfg_index,
  input  twc_pkg::cfg_data_t  cfg_data
);
  import twc_pkg::*;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : v + cnt_t'(1);
  endfunction

  // Galois step, one bit shifted out per call
  function automatic lfsr_t lfsr_step(input lfsr_t s);
    lfsr_step = {1'b0, s[LFSR_BITS-1:1]} ^ (s[0] ? LFSR_FEEDBACK : '0);
  endfunction

  // ---------------------------------------------------------------- control
  logic    in_accept;
  logic    s1_adv;

  logic    s1_valid_r, s1_valid_nxt;
  set_t    s1_set_r;
  tag_t    s1_tag_r;
  set_t    in_set;
  tag_t    in_tag;

  // bypass of a same-set tag write that coincided with the read
  logic    fwd0_r, fwd1_r;
  tag_t    fwd_tag_r;

  logic    out_valid_r, out_valid_nxt;
  logic    out_hit_r, out_replaced_r, out_way_r;
  set_t    out_set_r;

  // ---------------------------------------------------------------- state
  logic [SET_COUNT-1:0] v0_r, v1_r, older_r;
  policy_t policy_r;
  lfsr_t   lfsr_r, lfsr_adv;
  cnt_t    acc_cnt_r, hit_cnt_r, miss_cnt_r, evict_cnt_r;

  // ---------------------------------------------------------------- lookup
  tag_t    rd_tag0, rd_tag1, tag0, tag1;
  logic    v0, v1, hit0, hit1, hit, replace, way, victim, refresh;
  tag_wr_t wr0, wr1;

  assign in_set    = in_byte_address[OFFSET_BITS +: SET_BITS];
  assign in_tag    = in_byte_address[ADDR_BITS-1 -: TAG_BITS];

  assign s1_adv    = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall  = s1_valid_r & ~s1_adv;
  assign in_accept = in_valid & ~in_stall;

  twc_tag_ram u_way0 (
    .clk    (clk),
    .rd_en  (in_accept),
    .rd_set (in_set),
    .rd_tag (rd_tag0),
    .wr     (wr0)
  );

  twc_tag_ram u_way1 (
    .clk    (clk),
    .rd_en  (in_accept),
    .rd_set (in_set),
    .rd_tag (rd_tag1),
    .wr     (wr1)
  );

  assign tag0 = fwd0_r ? fwd_tag_r : rd_tag0;
  assign tag1 = fwd1_r ? fwd_tag_r : rd_tag1;

  assign v0   = v0_r[s1_set_r];
  assign v1   = v1_r[s1_set_r];
  assign hit0 = v0 & (tag0 == s1_tag_r);
  assign hit1 = v1 & (tag1 == s1_tag_r);
  assign hit  = hit0 | hit1;

  // Advance the LFSR only on a random-mode eviction
  assign lfsr_adv = lfsr_step(lfsr_r);
  assign replace  = ~hit & v0 & v1;
  assign victim   = (policy_r == POLICY_RANDOM) ? lfsr_adv[0] : older_r[s1_set_r];

  always_comb begin
    if (hit) begin
      way = ~hit0;
    end else if (!v0) begin
      way = 1'b0;
    end else if (!v1) begin
      way = 1'b1;
    end else begin
      way = victim;
    end
  end

  // Hits refresh recency in LRU mode and under the spare code only; fills always do
  assign refresh = ~hit | ((policy_r != POLICY_FIFO) && (policy_r != POLICY_RANDOM));

  always_comb begin
    wr0.we  = s1_adv & ~hit & ~way;
    wr0.set = s1_set_r;
    wr0.tag = s1_tag_r;
    wr1.we  = s1_adv & ~hit & way;
    wr1.set = s1_set_r;
    wr1.tag = s1_tag_r;
  end

  assign s1_valid_nxt  = in_accept | (s1_valid_r & ~s1_adv);
  assign out_valid_nxt = s1_adv | (out_valid_r & out_stall);

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the word and note whether this edge's fill hits the set being read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_set_r  <= in_set;
      s1_tag_r  <= in_tag;
      fwd0_r    <= wr0.we & (wr0.set == in_set);
      fwd1_r    <= wr1.we & (wr1.set == in_set);
      fwd_tag_r <= s1_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_hit_r      <= hit;
      out_replaced_r <= replace;
      out_way_r      <= way;
      out_set_r      <= s1_set_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= '0;
      v1_r    <= '0;
      older_r <= '0;
    end else if (s1_adv) begin
      if (wr0.we) begin
        v0_r[s1_set_r] <= 1'b1;
      end
      if (wr1.we) begin
        v1_r[s1_set_r] <= 1'b1;
      end
      if (refresh) begin
        older_r[s1_set_r] <= ~way;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r   <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else if (s1_adv) begin
      acc_cnt_r <= sat_inc(acc_cnt_r);
      if (hit) begin
        hit_cnt_r <= sat_inc(hit_cnt_r);
      end else begin
        miss_cnt_r <= sat_inc(miss_cnt_r);
      end
      if (replace) begin
        evict_cnt_r <= sat_inc(evict_cnt_r);
      end
    end
  end

  // Configuration; a seed write reloads the LFSR, zero forced to one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_LRU;
      lfsr_r   <= LFSR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY: policy_r <= cfg_data[1:0];
        CFG_SEED:   lfsr_r   <= (cfg_data == '0) ? lfsr_t'(1) : cfg_data[LFSR_BITS-1:0];
        default:    ;
      endcase
    end else if (s1_adv && replace && (policy_r == POLICY_RANDOM)) begin
      lfsr_r <= lfsr_adv;
    end
  end

  // ---------------------------------------------------------------- outputs
  // Totals change only when a new result enters the output register
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_replaced      = out_replaced_r;
  assign out_way_used      = out_way_r;
  assign out_set_index     = out_set_r;
  assign out_access_total  = acc_cnt_r;
  assign out_hit_total     = hit_cnt_r;
  assign out_miss_total    = miss_cnt_r;
  assign out_replace_total = evict_cnt_r;

endmodule

// ----- rtl/twc_tag_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_tag_ram: tag store of one way
// One write port and one registered read port, read data held between reads.
// ----------------------------------------------------------------------------
module twc_tag_ram (
  input  logic            clk,
  input  logic            rd_en,
  input  twc_pkg::set_t   rd_set,
  output twc_pkg::tag_t   rd_tag,
  input  twc_pkg::tag_wr_t wr
);
  import twc_pkg::*;

  tag_t mem [SET_COUNT];
  tag_t rd_tag_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.set] <= wr.tag;
    end
  end

  // Read before write: a same-set write in this cycle is bypassed upstream
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tag_r <= mem[rd_set];
    end
  end

  assign rd_tag = rd_tag_r;

endmodule

// ----- dv/twc_lookup_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twc_lookup_checker: result checker of the two-way cache tag controller
// Keeps its own copy of tags, valid and recency bits, victim LFSR, totals and
// policy, predicts every accepted lookup and compares each result word with
// the oldest prediction.
// ----------------------------------------------------------------------------
module twc_lookup_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  twc_pkg::addr_t     in_byte_address,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               out_hit,
  input  logic               out_replaced,
  input  logic               out_way_used,
  input  twc_pkg::set_t      out_set_index,
  input  twc_pkg::cnt_t      out_access_total,
  input  twc_pkg::cnt_t      out_hit_total,
  input  twc_pkg::cnt_t      out_miss_total,
  input  twc_pkg::cnt_t      out_replace_total,
  input  logic               cfg_we,
  input  twc_pkg::cfg_idx_t  cfg_index,
  input  twc_pkg::cfg_data_t cfg_data,
  output int                 fail_count,
  output int                 outstanding
);

  import twc_pkg::*;

  typedef struct packed {
    logic hit;
    logic replaced;
    logic way_used;
    set_t set_index;
    cnt_t access_total;
    cnt_t hit_total;
    cnt_t miss_total;
    cnt_t replace_total;
  } lookup_t;

  logic    way0_valid [SET_COUNT];
  logic    way1_valid [SET_COUNT];
  tag_t    way0_tag   [SET_COUNT];
  tag_t    way1_tag   [SET_COUNT];
  logic    older_way  [SET_COUNT];
  lfsr_t   victim_lfsr;
  policy_t policy;
  cnt_t    accesses;
  cnt_t    hits;
  cnt_t    misses;
  cnt_t    evictions;
  lookup_t expected_lookups [$];

  function automatic cnt_t sat_inc(cnt_t c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // One lookup: update the mirrored state and return the word it produces.
  function automatic lookup_t predict_lookup(addr_t addr);
    set_t    s;
    tag_t    t;
    logic    way;
    lookup_t r;
    s   = addr[OFFSET_BITS +: SET_BITS];
    t   = addr[ADDR_BITS-1 -: TAG_BITS];
    way = 1'b0;
    r   = '0;
    accesses = sat_inc(accesses);
    if (way0_valid[s] && way0_tag[s] == t) begin
      r.hit = 1'b1;
      way   = 1'b0;
    end else if (way1_valid[s] && way1_tag[s] == t) begin
      r.hit = 1'b1;
      way   = 1'b1;
    end
    if (r.hit) begin
      hits = sat_inc(hits);
      if (policy != POLICY_FIFO && policy != POLICY_RANDOM) older_way[s] = ~way;
    end else begin
      misses = sat_inc(misses);
      if (!way0_valid[s]) begin
        way = 1'b0;
      end else if (!way1_valid[s]) begin
        way = 1'b1;
      end else begin
        r.replaced = 1'b1;
        evictions  = sat_inc(evictions);
        if (policy == POLICY_RANDOM) begin
          victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_FEEDBACK)
                                       : (victim_lfsr >> 1);
          way = victim_lfsr[0];
        end else begin
          way = older_way[s];
        end
      end
      if (way) begin
        way1_valid[s] = 1'b1;
        way1_tag[s]   = t;
      end else begin
        way0_valid[s] = 1'b1;
        way0_tag[s]   = t;
      end
      older_way[s] = ~way;
    end
    r.way_used      = way;
    r.set_index     = s;
    r.access_total  = accesses;
    r.hit_total     = hits;
    r.miss_total    = misses;
    r.replace_total = evictions;
    return r;
  endfunction

  function automatic int count_mismatch(string name, cnt_t want, cnt_t got);
    if (want === got) return 0;
    $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (!rst_n) begin
      foreach (way0_valid[i]) begin
        way0_valid[i] = 1'b0;
        way1_valid[i] = 1'b0;
        way0_tag[i]   = '0;
        way1_tag[i]   = '0;
        older_way[i]  = 1'b0;
      end
      policy      = POLICY_LRU;
      victim_lfsr = LFSR_RESET;
      accesses    = '0;
      hits        = '0;
      misses      = '0;
      evictions   = '0;
      expected_lookups.delete();
    end else begin
      // Compare before predicting: a word accepted now is never due at once.
      if (out_valid && !out_stall) begin
        got = {out_hit, out_replaced, out_way_used, out_set_index, out_access_total,
               out_hit_total, out_miss_total, out_replace_total};
        if (expected_lookups.size() == 0) begin
          $display("%0t: result word with no lookup pending, got %h", $time, got);
          fail_count++;
        end else begin
          want = expected_lookups.pop_front();
          fail_count += count_mismatch("hit", cnt_t'(want.hit), cnt_t'(got.hit));
          fail_count += count_mismatch("replaced", cnt_t'(want.replaced),
                                       cnt_t'(got.replaced));
          fail_count += count_mismatch("way_used", cnt_t'(want.way_used),
                                       cnt_t'(got.way_used));
          fail_count += count_mismatch("set_index", cnt_t'(want.set_index),
                                       cnt_t'(got.set_index));
          fail_count += count_mismatch("access_total", want.access_total,
                                       got.access_total);
          fail_count += count_mismatch("hit_total", want.hit_total, got.hit_total);
          fail_count += count_mismatch("miss_total", want.miss_total, got.miss_total);
          fail_count += count_mismatch("replace_total", want.replace_total,
                                       got.replace_total);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_POLICY) begin
          policy = cfg_data[1:0];
        end else if (cfg_index == CFG_SEED) begin
          // a zero seed would lock the LFSR, so it loads as one
          victim_lfsr = (cfg_data == '0) ? lfsr_t'(1) : lfsr_t'(cfg_data);
        end
      end
      if (in_valid && !in_stall) expected_lookups.push_back(predict_lookup(in_byte_address));
    end
    outstanding = expected_lookups.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the two-way cache tag controller
// Drives byte addresses through a directed opening (fills, hits, evictions
// under each policy, seed zero) and then random phases of hot-set traffic
// with reused and scattered addresses, a policy set per phase and some
// seeds loaded. Random gaps and stalls hit both channels until the last phase.
// ----------------------------------------------------------------------------
module tb_top;

  import twc_pkg::*;

  localparam int      IDLE_LIMIT   = 2000;
  localparam int      PHASES       = 8;
  localparam int      PHASE_WORDS  = 225;
  // the spare policy code, which the block treats as LRU
  localparam policy_t POLICY_SPARE = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  addr_t     in_byte_address;
  logic      out_valid;
  logic      out_stall;
  logic      out_hit;
  logic      out_replaced;
  logic      out_way_used;
  set_t      out_set_index;
  cnt_t      out_access_total;
  cnt_t      out_hit_total;
  cnt_t      out_miss_total;
  cnt_t      out_replace_total;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  int fail_count;
  int outstanding;
  int idle_cycles;
  bit calm;

  two_way_cache_tag_controller uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_address   (in_byte_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_replaced      (out_replaced),
    .out_way_used      (out_way_used),
    .out_set_index     (out_set_index),
    .out_access_total  (out_access_total),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total),
    .out_replace_total (out_replace_total),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  twc_lookup_checker lookup_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_address   (in_byte_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_replaced      (out_replaced),
    .out_way_used      (out_way_used),
    .out_set_index     (out_set_index),
    .out_access_total  (out_access_total),
    .out_hit_total     (out_hit_total),
    .out_miss_total    (out_miss_total),
    .out_replace_total (out_replace_total),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: give up once no word has moved on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("two_way_cache_tag_controller verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: stall in random bursts, always dropping the stall between two
  // bursts; hold off entirely once the run turns calm.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Present one address and hold it until the block takes it. Valid is only
  // dropped for a gap, so it never falls and rises within one edge.
  task automatic send_lookup(addr_t a);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte_address <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_list(input addr_t words[$]);
    foreach (words[i]) send_lookup(words[i]);
  endtask

  // Wait until every lookup has come back, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write the policy (with junk in the upper bits) and optionally the seed.
  task automatic write_config(policy_t pol, bit load_seed, lfsr_t seed);
    cfg_data_t d;
    d       = cfg_data_t'($urandom);
    d[1:0]  = pol;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POLICY;
    cfg_data  <= d;
    @(posedge clk);
    if (load_seed) begin
      cfg_index <= CFG_SEED;
      cfg_data  <= seed;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    addr_t   words [$];
    addr_t   recent [$];
    addr_t   a;
    tag_t    hot_tag;
    set_t    hot_set;
    policy_t pol;
    bit      load_seed;
    lfsr_t   seed;
    int      pick;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_byte_address <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_POLICY;
    cfg_data        <= '0;
    calm             = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // LRU from reset: cold miss on tag zero, offset-only hits, fill of way
    // one, recency refresh by a hit, eviction of each way in turn, top set
    // with all-ones tag, and alternating bit patterns.
    words = '{32'h0000_0000, 32'h0000_0005, 32'hFFFF_FFFF, 32'h0000_0400,
              32'h0000_000F, 32'h0000_0800, 32'h0000_0400, 32'h7FFF_FFF0,
              32'hFFFF_FFF0, 32'hAAAA_AAAA, 32'h5555_5555};
    send_list(words);
    drain();

    // FIFO: a hit must not refresh recency, so the first-filled way goes.
    write_config(POLICY_FIFO, 1'b0, '0);
    words = '{32'h0000_0010, 32'h0000_0410, 32'h0000_0010, 32'h0000_0810};
    send_list(words);
    drain();

    // Random victim from the reset seed.
    write_config(POLICY_RANDOM, 1'b0, '0);
    words = '{32'h0000_0020, 32'h0000_0420, 32'h0000_0820, 32'h0000_0C20,
              32'h0000_1020, 32'h0000_0020};
    send_list(words);
    drain();

    // Spare policy code behaves as LRU; load a zero seed alongside.
    write_config(POLICY_SPARE, 1'b1, 16'h0000);
    words = '{32'h0000_0030, 32'h0000_0430, 32'h0000_0030, 32'h0000_0830};
    send_list(words);

    // Random phases: mostly a hot group of four sets and four tags so that
    // hits and evictions are frequent, plus reuse of recent addresses and
    // fully scattered ones.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin  // random victims from the LFSR that the zero seed left
          pol = POLICY_RANDOM; load_seed = 1'b0; seed = '0;
        end
        1: begin
          pol = POLICY_RANDOM; load_seed = 1'b1; seed = 16'hFFFF;
        end
        2: begin
          pol = POLICY_LRU; load_seed = 1'b1; seed = 16'h0001;
        end
        3: begin
          pol = POLICY_FIFO; load_seed = 1'b1; seed = lfsr_t'($urandom);
        end
        default: begin
          pol       = policy_t'($urandom_range(0, 3));
          load_seed = $urandom_range(0, 1) != 0;
          seed      = ($urandom_range(0, 7) == 0) ? '0 : lfsr_t'($urandom);
        end
      endcase
      write_config(pol, load_seed, seed);
      calm    = (p == PHASES - 1);
      hot_tag = (p == 1) ? '1 : tag_t'($urandom);
      hot_set = set_t'($urandom);
      repeat (PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          a = {tag_t'(hot_tag + tag_t'($urandom_range(0, 3))),
               set_t'(hot_set + set_t'($urandom_range(0, 3))),
               OFFSET_BITS'($urandom)};
        end else if (pick < 85 && recent.size() > 0) begin
          a = recent[$urandom_range(0, recent.size() - 1)];
        end else begin
          a = addr_t'($urandom);
        end
        recent.push_back(a);
        if (recent.size() > 8) void'(recent.pop_front());
        send_lookup(a);
      end
    end
    drain();

    if (fail_count == 0 && outstanding == 0) begin
      $display("two_way_cache_tag_controller verification clean");
    end else begin
      $display("two_way_cache_tag_controller verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/twc_pkg.sv
rtl/twc_tag_ram.sv
rtl/two_way_cache_tag_controller.sv
dv/twc_lookup_checker.sv
dv/tb_top.sv
